// ----- rtl/eapg_pkg.sv -----
// package for the ellipse arc point generator
// holds defaults, the cordic angle table, the register index codes and cell types
package eapg_pkg;

  localparam int MAX_POINTS_DEF    = 1024;
  localparam int ANGLE_BITS_DEF    = 16;
  localparam int COORD_BITS_DEF    = 16;
  localparam int CORDIC_STAGES_DEF = 16;

  localparam int IDX_W   = 10;
  localparam int CNT_W   = 11;
  localparam int RAD_W   = 16;
  localparam int ANG_W   = 16;
  localparam int DIV_W   = 27;
  localparam int PH_W    = 32;
  localparam int CD_W    = 34;
  localparam logic signed [CD_W-1:0] GAIN_Q30 = 34'sd652032874;

  typedef enum logic [2:0] {
    REG_RADIUS_X    = 3'd0,
    REG_RADIUS_Y    = 3'd1,
    REG_START_ANGLE = 3'd2,
    REG_END_ANGLE   = 3'd3,
    REG_POINT_COUNT = 3'd4,
    REG_FULL_TURN   = 3'd5
  } reg_idx_t;

  typedef struct packed {
    logic                    vld;
    logic                    flip;
    logic signed [CD_W-1:0]  x;
    logic signed [CD_W-1:0]  y;
    logic signed [PH_W:0]    z;
  } cordic_tok_t;

  function automatic logic signed [PH_W:0] atan_turn(input int i);
    logic signed [PH_W:0] r;
    case (i)
      0: r = 33'sd536870912;   1: r = 33'sd316933406;
      2: r = 33'sd167458907;   3: r = 33'sd85004756;
      4: r = 33'sd42667331;    5: r = 33'sd21354465;
      6: r = 33'sd10679838;    7: r = 33'sd5340245;
      8: r = 33'sd2670163;     9: r = 33'sd1335087;
      10: r = 33'sd667544;     11: r = 33'sd333772;
      12: r = 33'sd166886;     13: r = 33'sd83443;
      14: r = 33'sd41722;      15: r = 33'sd20861;
      16: r = 33'sd10430;      17: r = 33'sd5215;
      18: r = 33'sd2608;       19: r = 33'sd1304;
      20: r = 33'sd652;        21: r = 33'sd326;
      22: r = 33'sd163;        23: r = 33'sd81;
      24: r = 33'sd41;         25: r = 33'sd20;
      26: r = 33'sd10;         27: r = 33'sd5;
      28: r = 33'sd3;          29: r = 33'sd1;
      30: r = 33'sd1;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

// ----- rtl/eapg_div_cell.sv -----
// one restoring division cell: one quotient bit per cell
// depends on eapg_pkg
module eapg_div_cell import eapg_pkg::*; #(
  parameter int BIT = 0
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  logic             in_vld,
  input  logic [DIV_W-1:0] in_rem,
  input  logic [DIV_W-1:0] in_quo,
  input  logic [CNT_W-1:0] in_den,
  input  logic [ANG_W-1:0] in_end,
  input  logic             in_zero,
  output logic             out_vld,
  output logic [DIV_W-1:0] out_rem,
  output logic [DIV_W-1:0] out_quo,
  output logic [CNT_W-1:0] out_den,
  output logic [ANG_W-1:0] out_end,
  output logic             out_zero
);
  logic [DIV_W+CNT_W-1:0] sh;
  logic                   ge;

  always_comb begin
    sh = {{CNT_W{1'b0}}, in_rem} >> BIT;
    ge = sh >= {{DIV_W{1'b0}}, in_den};
  end

  always_ff @(posedge clk) begin
    if (rst) out_vld <= 1'b0;
    else if (en) out_vld <= in_vld;
    if (en) begin
      out_rem  <= ge ? in_rem - DIV_W'({{DIV_W{1'b0}}, in_den} << BIT) : in_rem;
      out_quo  <= in_quo | (DIV_W'(ge) << BIT);
      out_den  <= in_den;
      out_end  <= in_end;
      out_zero <= in_zero;
    end
  end
endmodule

// ----- rtl/eapg_cordic_cell.sv -----
// one cordic rotation cell, shift and angle set by its place in the row
// depends on eapg_pkg
module eapg_cordic_cell import eapg_pkg::*; #(
  parameter int STAGE = 0
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        en,
  input  cordic_tok_t in_tok,
  output cordic_tok_t out_tok
);
  localparam logic signed [PH_W:0] ATAN = atan_turn(STAGE);
  logic signed [CD_W-1:0] xs, ys;

  always_comb begin
    xs = in_tok.x >>> STAGE;
    ys = in_tok.y >>> STAGE;
  end

  always_ff @(posedge clk) begin
    if (rst) out_tok.vld <= 1'b0;
    else if (en) out_tok.vld <= in_tok.vld;
    if (en) begin
      out_tok.flip <= in_tok.flip;
      if (!in_tok.z[PH_W]) begin
        out_tok.x <= in_tok.x - ys;
        out_tok.y <= in_tok.y + xs;
        out_tok.z <= in_tok.z - ATAN;
      end else begin
        out_tok.x <= in_tok.x + ys;
        out_tok.y <= in_tok.y - xs;
        out_tok.z <= in_tok.z + ATAN;
      end
    end
  end
endmodule

// ----- rtl/ellipse_arc_point_generator_unit.sv -----
// throughput: one point per cycle through the divider and cordic cell rows;
// the whole pipe holds while a result waits at the output
// reset: synchronous; clears valid bits and sets the config registers to their defaults
// top level of the ellipse arc point generator
// depends on eapg_pkg, eapg_div_cell, eapg_cordic_cell
module ellipse_arc_point_generator_unit import eapg_pkg::*; #(
  parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,  // point_index[9:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata   // vertex_x[15:0], vertex_y[31:16]
);
  localparam int NS  = (CORDIC_STAGES < 32) ? CORDIC_STAGES : 32;

  logic signed [RAD_W-1:0] rad_x, rad_y;
  logic [ANG_W-1:0] ang_s, ang_e;
  logic [CNT_W-1:0] cnt;
  logic             full;

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      rad_x <= 16'sd4096; rad_y <= 16'sd4096; ang_s <= '0; ang_e <= '0;
      cnt <= 11'd64; full <= 1'b1;
    end else if (cfg_valid) begin
      case (reg_idx_t'(cfg_index))
        REG_RADIUS_X:    rad_x <= cfg_data;
        REG_RADIUS_Y:    rad_y <= cfg_data;
        REG_START_ANGLE: ang_s <= cfg_data;
        REG_END_ANGLE:   ang_e <= cfg_data;
        REG_POINT_COUNT: cnt   <= cfg_data[CNT_W-1:0];
        REG_FULL_TURN:   full  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // the whole pipe advances together and holds while a result waits
  logic en, acc;
  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;
  assign acc      = s_tvalid && s_tready;

  // stage 0: span and product
  logic             p0_v, p0_z;
  logic [DIV_W-1:0] p0_num;
  logic [CNT_W-1:0] p0_den;
  logic [ANG_W-1:0] p0_end;
  logic [ANG_W:0]   span;
  logic [CNT_W-1:0] cc;
  always_comb begin
    span = full ? (ANG_W+1)'(1) << ANG_W : {1'b0, ang_e - ang_s};
    cc = (cnt > CNT_W'(MAX_POINTS_DEF)) ? CNT_W'(MAX_POINTS_DEF) : cnt;
  end
  always_ff @(posedge clk) begin
    if (rst) p0_v <= 1'b0;
    else if (en) p0_v <= acc;
    if (en) begin
      p0_num <= DIV_W'(s_tdata[IDX_W-1:0] * span);
      p0_den <= cc - 1'b1;
      p0_z   <= cc < 2;
      p0_end <= ang_e;
    end
  end
  // stage 1: add rounding half
  logic             p1_v, p1_z;
  logic [DIV_W-1:0] p1_num;
  logic [CNT_W-1:0] p1_den;
  logic [ANG_W-1:0] p1_end;
  always_ff @(posedge clk) begin
    if (rst) p1_v <= 1'b0;
    else if (en) p1_v <= p0_v;
    if (en) begin
      p1_num <= p0_num + DIV_W'(p0_den >> 1);
      p1_den <= p0_z ? CNT_W'(1) : p0_den;
      p1_z <= p0_z; p1_end <= p0_end;
    end
  end

  logic             dv  [DIV_W+1];
  logic [DIV_W-1:0] dr  [DIV_W+1];
  logic [DIV_W-1:0] dq  [DIV_W+1];
  logic [CNT_W-1:0] dd  [DIV_W+1];
  logic [ANG_W-1:0] de  [DIV_W+1];
  logic             dz  [DIV_W+1];
  assign dv[0] = p1_v; assign dr[0] = p1_num; assign dq[0] = '0;
  assign dd[0] = p1_den; assign de[0] = p1_end; assign dz[0] = p1_z;
  for (genvar g = 0; g < DIV_W; g++) begin : g_div
    eapg_div_cell #(.BIT(DIV_W-1-g)) u_cell (
      .clk, .rst, .en, .in_vld(dv[g]), .in_rem(dr[g]), .in_quo(dq[g]), .in_den(dd[g]),
      .in_end(de[g]), .in_zero(dz[g]), .out_vld(dv[g+1]), .out_rem(dr[g+1]),
      .out_quo(dq[g+1]), .out_den(dd[g+1]), .out_end(de[g+1]), .out_zero(dz[g+1]));
  end

  // stage: angle, quadrant fold
  logic [ANG_W-1:0] ang;
  logic [PH_W-1:0]  ph, phf;
  logic             flp;
  cordic_tok_t      tk [NS+1];
  always_comb begin
    ang = de[DIV_W] - (dz[DIV_W] ? ANG_W'(0) : dq[DIV_W][ANG_W-1:0]);
    ph  = {ang, {(PH_W-ANG_W){1'b0}}};
    flp = ph[PH_W-1] ^ ph[PH_W-2];
    phf = flp ? ph + 32'h8000_0000 : ph;
  end
  always_ff @(posedge clk) begin
    if (rst) tk[0].vld <= 1'b0;
    else if (en) tk[0].vld <= dv[DIV_W];
    if (en) begin
      tk[0].flip <= flp;
      tk[0].x <= GAIN_Q30;
      tk[0].y <= '0;
      tk[0].z <= {phf[PH_W-1], phf};
    end
  end
  for (genvar g = 0; g < NS; g++) begin : g_cor
    eapg_cordic_cell #(.STAGE(g)) u_cell (
      .clk, .rst, .en, .in_tok(tk[g]), .out_tok(tk[g+1]));
  end

  // multiply then round and saturate
  logic signed [CD_W-1:0] cs, sn;
  logic signed [CD_W+RAD_W-1:0] mx, my;
  logic m_v, f_v;
  assign cs = tk[NS].flip ? -tk[NS].x : tk[NS].x;
  assign sn = tk[NS].flip ? -tk[NS].y : tk[NS].y;
  always_ff @(posedge clk) begin
    if (rst) m_v <= 1'b0;
    else if (en) m_v <= tk[NS].vld;
    if (en) begin
      mx <= rad_x * cs;
      my <= rad_y * sn;
    end
  end
  function automatic logic [15:0] sat(input logic signed [CD_W+RAD_W-1:0] p);
    logic signed [CD_W+RAD_W-1:0] r;
    r = (p + (CD_W+RAD_W)'(64'sd1 <<< 29)) >>> 30;
    if (r > 32767) return 16'h7fff;
    if (r < -32768) return 16'h8000;
    return r[15:0];
  endfunction
  // output register
  logic [31:0] f_d;
  always_ff @(posedge clk) begin
    if (rst) f_v <= 1'b0;
    else if (en) f_v <= m_v;
    if (en) f_d <= {sat(my), sat(mx)};
  end
  assign m_tvalid = f_v;
  assign m_tdata  = f_d;
endmodule
